FILE: hdl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and constants for the trailing blank stripper
// Holds the store depth, character codes, index types and the command and
// status groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package tbs_pkg;

   // Depth of the pending blank store
   localparam int MAX_PENDING = 63;

   // Count holds 0..MAX_PENDING; index addresses 0..MAX_PENDING-1
   localparam int CNT_W = $clog2(MAX_PENDING + 1);
   localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [IDX_W-1:0] idx_type;

   // Character codes
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Controller to datapath
   typedef struct packed {
      logic take;         // input item accepted this cycle
      logic emit_now;     // load the input byte as a final result
      logic start_drain;  // read store entry 0, point at entry 1
      logic emit_blank;   // load the blank just read as a result
      logic read_next;    // read the next store entry
      logic emit_final;   // load the held printable byte, close the item
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_blank;
      logic is_newline;
      logic count_zero;
      logic more_pending;
      logic line_has_text;
      logic out_free;
   } sts_type;

endpackage

FILE: hdl/tbs_req_if.sv
// ----------------------------------------------------------------------------
// tbs_req_if: input channel of the trailing blank stripper
// One text byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hdl/tbs_rsp_if.sv
// ----------------------------------------------------------------------------
// tbs_rsp_if: result channel of the trailing blank stripper
// One cleaned byte per item with last and sticky overflow flags.
// ----------------------------------------------------------------------------
interface tbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       overflowed;

   modport source (output valid, output out_byte, output last, output overflowed,
                   input ready);
   modport sink   (input valid, input out_byte, input last, input overflowed,
                   output ready);
endinterface

FILE: hdl/tbs_ctrl.sv
// ----------------------------------------------------------------------------
// tbs_ctrl: sequencing for the trailing blank stripper
// Takes input bytes while idle, then walks the held blanks out one per cycle
// while the output is free and ends with the printable byte that released them.
// ----------------------------------------------------------------------------
module tbs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tbs_pkg::sts_type sts,
   output tbs_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               cmd.take = 1'b1;
               if (sts.is_newline) begin
                  cmd.emit_now = sts.line_has_text;
               end else if (!sts.is_blank) begin
                  if (sts.count_zero) begin
                     cmd.emit_now = 1'b1;
                  end else begin
                     cmd.start_drain = 1'b1;
                     state_in        = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (sts.out_free) begin
               cmd.emit_blank = 1'b1;
               if (sts.more_pending) begin
                  cmd.read_next = 1'b1;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/tbs_dpath.sv
// ----------------------------------------------------------------------------
// tbs_dpath: storage and output register for the trailing blank stripper
// Pending blank store, its count and read pointer, line and overflow flags,
// the held printable byte and the result register.
// ----------------------------------------------------------------------------
module tbs_dpath (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_in_byte,
   input  tbs_pkg::cmd_type cmd,
   output tbs_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_overflowed
);

   logic                 mem [tbs_pkg::MAX_PENDING];
   logic                 rd_data_ff;
   tbs_pkg::cnt_type     count_ff;
   tbs_pkg::cnt_type     rd_idx_ff;
   logic                 line_text_ff;
   logic                 overflow_ff;
   logic [7:0]           byte_ff;
   logic                 out_valid_ff;
   logic [7:0]           out_byte_ff;
   logic                 out_last_ff;
   logic                 out_ovf_ff;
   logic                 is_blank;
   logic                 is_tab;
   logic                 is_newline;
   logic                 full;
   logic                 wr_en;
   logic                 rd_en;
   tbs_pkg::idx_type     rd_addr;

   // Byte class and store status
   assign is_tab     = (req_in_byte == tbs_pkg::CH_TAB);
   assign is_blank   = (req_in_byte == tbs_pkg::CH_SPACE) || is_tab;
   assign is_newline = (req_in_byte == tbs_pkg::CH_NEWLINE);
   assign full       = (count_ff == tbs_pkg::cnt_type'(tbs_pkg::MAX_PENDING));
   assign wr_en      = cmd.take && is_blank && !full;

   assign sts.is_blank      = is_blank;
   assign sts.is_newline    = is_newline;
   assign sts.count_zero    = (count_ff == '0);
   assign sts.more_pending  = (rd_idx_ff != count_ff);
   assign sts.line_has_text = line_text_ff;
   assign sts.out_free      = !out_valid_ff || rsp_ready;

   // Pending store, one write and one registered read port
   assign rd_en   = cmd.start_drain || cmd.read_next;
   assign rd_addr = cmd.start_drain ? '0 : rd_idx_ff[tbs_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[tbs_pkg::IDX_W-1:0]] <= is_tab;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Read pointer and held printable byte
   always_ff @(posedge clock) begin
      if (cmd.start_drain) begin
         rd_idx_ff <= tbs_pkg::cnt_type'(1);
      end else if (cmd.read_next) begin
         rd_idx_ff <= rd_idx_ff + tbs_pkg::cnt_type'(1);
      end
      if (cmd.take) begin
         byte_ff <= req_in_byte;
      end
   end

   // Count, line and overflow flags
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         line_text_ff <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         if (cmd.take && is_blank) begin
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + tbs_pkg::cnt_type'(1);
            end
         end else if (cmd.take && is_newline) begin
            count_ff     <= '0;
            line_text_ff <= 1'b0;
         end else if (cmd.take && cmd.emit_now) begin
            line_text_ff <= 1'b1;
         end
         if (cmd.emit_final) begin
            count_ff     <= '0;
            line_text_ff <= 1'b1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_now || cmd.emit_blank || cmd.emit_final) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_now) begin
         out_byte_ff <= req_in_byte;
         out_last_ff <= 1'b1;
         out_ovf_ff  <= overflow_ff;
      end else if (cmd.emit_blank) begin
         out_byte_ff <= rd_data_ff ? tbs_pkg::CH_TAB : tbs_pkg::CH_SPACE;
         out_last_ff <= 1'b0;
         out_ovf_ff  <= overflow_ff;
      end else if (cmd.emit_final) begin
         out_byte_ff <= byte_ff;
         out_last_ff <= 1'b1;
         out_ovf_ff  <= overflow_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_overflowed = out_ovf_ff;

endmodule

FILE: hdl/trailing_blank_stripper.sv
// A printable byte with no blanks held, or a newline ending a line with text, is loaded
// into the result register when accepted. A printable byte after N held blanks gives N+1
// results, one per cycle while the output is free: store entry 0 is read at acceptance,
// then each blank and last the printable byte is loaded; input is held off meanwhile.
// Reset (synchronous) empties the store count, clears line and overflow flags and the
// result valid flag; store contents are not cleared.
// ----------------------------------------------------------------------------
// trailing_blank_stripper: removes trailing blanks and blank lines
// Top level joining the sequencing controller and the blank store datapath.
// ----------------------------------------------------------------------------
module trailing_blank_stripper (
   input logic      clock,
   input logic      reset,
   tbs_req_if.sink  req_bus,
   tbs_rsp_if.source rsp_bus
);

   tbs_pkg::cmd_type cmd;
   tbs_pkg::sts_type sts;

   tbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tbs_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_in_byte    (req_bus.in_byte),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_out_byte   (rsp_bus.out_byte),
      .rsp_last       (rsp_bus.last),
      .rsp_overflowed (rsp_bus.overflowed)
   );

   // Only one source loads the result register at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_now, cmd.emit_blank, cmd.emit_final}))
      else $error("more than one result load in a cycle");

   // Draining only happens with blanks held
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_blank || cmd.start_drain) |-> !sts.count_zero)
      else $error("drain with empty store");

   // A newline always empties the store
   assert property (@(posedge clock) disable iff (reset)
      (cmd.take && sts.is_newline) |=> sts.count_zero)
      else $error("store not emptied by newline");

   // Closing a drained item leaves the line marked as having text
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_final |=> (sts.line_has_text && sts.count_zero))
      else $error("line state wrong after drain");

endmodule
